// File: src/csv_field_splitter_macros.svh
// ----------------------------------------------------------------------------
// csv_field_splitter assertion macros
// Short forms for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

// Assertion that is checked only outside reset.
`define CSVFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked across reset.
`define CSVFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared constants, byte codes and types of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  // Row and field limits.
  localparam int MAX_FIELDS  = 32;
  localparam int FIELD_BYTES = 64;

  // Widths: stored length, field counter, field number, store address.
  localparam int LEN_W  = $clog2(FIELD_BYTES);
  localparam int FCNT_W = $clog2(MAX_FIELDS + 1);
  localparam int NUM_W  = 5;
  localparam int MEM_AW = LEN_W + 1;

  // Byte codes the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Write port of the field store.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // One finished field, handed from the parser to the emitter.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic             empty;
    logic [NUM_W-1:0] num;
    logic             row_end;
  } field_cmd_t;

  // Notice that a store bank has been read out completely.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Whitespace as the trimming sees it: space and codes 9 through 13.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: src/csvfs_front.sv
// ----------------------------------------------------------------------------
// csvfs_front
// Parser: takes one byte at a time, runs the field state machine, writes
// field bytes into the current store bank and issues one command per field.
// ----------------------------------------------------------------------------
module csvfs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_line,
  output csvfs_pkg::store_wr_t wr,
  output logic                 cmd_push,
  output csvfs_pkg::field_cmd_t cmd,
  input  logic                 cmd_full,
  input  csvfs_pkg::bank_rel_t rel
);
  import csvfs_pkg::*;

  // Parse phases.
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_LF_FIRST = 3'd1;
  localparam logic [2:0] PH_LEAD     = 3'd2;
  localparam logic [2:0] PH_UNQ      = 3'd3;
  localparam logic [2:0] PH_QUO      = 3'd4;
  localparam logic [2:0] PH_QUO_Q    = 3'd5;
  localparam logic [2:0] PH_AFTER    = 3'd6;
  localparam logic [2:0] PH_DONE     = 3'd7;

  logic              hold_valid;
  logic              line_step;
  logic [7:0]        hold_byte;
  logic              hold_eol;
  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [2:0]        eff_phase;
  logic [LEN_W-1:0]  stored_length;
  logic [FCNT_W-1:0] fields_done;
  logic [FCNT_W-1:0] fields_done_next;
  logic              cur_bank;
  logic [1:0]        busy;
  logic [1:0]        busy_next;
  logic              seen;
  logic [LEN_W-1:0]  trim_lo;
  logic [LEN_W-1:0]  trim_hi;

  logic ws;
  logic is_lf;
  logic is_cr;
  logic is_quote;
  logic is_comma;
  logic at_max;
  logic append_ok;
  logic want_emit;
  logic want_append;
  logic row_end;
  logic line_restart;
  logic stall;
  logic go;

  // One byte is held at a time; it is worked off in one or two steps.
  assign full = hold_valid;

  // Byte classification and field limits.
  always_comb begin
    ws        = is_space(hold_byte);
    is_lf     = (hold_byte == CH_LF);
    is_cr     = (hold_byte == CH_CR);
    is_quote  = (hold_byte == CH_QUOTE);
    is_comma  = (hold_byte == CH_COMMA);
    at_max    = (fields_done == FCNT_W'(MAX_FIELDS - 1));
    append_ok = (stored_length < LEN_W'(FIELD_BYTES - 1));
  end

  // Resolve the phases that hand the same byte on to another phase.
  always_comb begin
    eff_phase = phase;
    if ((eff_phase == PH_START) && !is_lf) begin
      eff_phase = PH_LEAD;
    end
    if ((eff_phase == PH_LEAD) && !(ws && !is_lf) && !is_quote) begin
      eff_phase = PH_UNQ;
    end
    if ((eff_phase == PH_QUO_Q) && !is_quote) begin
      eff_phase = PH_AFTER;
    end
  end

  // Field state machine: the byte step first, then the line end step.
  always_comb begin
    phase_next       = phase;
    fields_done_next = fields_done;
    want_emit        = 1'b0;
    want_append      = 1'b0;
    row_end          = 1'b0;
    line_restart     = 1'b0;
    if (hold_valid) begin
      if (!line_step) begin
        if (hold_byte != CH_NUL) begin
          phase_next = eff_phase;
          unique case (eff_phase) inside
            PH_START: begin
              phase_next = PH_LF_FIRST;
            end
            PH_LF_FIRST: begin
              want_emit  = 1'b1;
              row_end    = 1'b1;
              phase_next = PH_DONE;
            end
            PH_LEAD: begin
              if (is_quote) begin
                phase_next = PH_QUO;
              end
            end
            PH_UNQ, PH_AFTER: begin
              if (is_comma) begin
                want_emit = 1'b1;
                row_end   = at_max;
                if (at_max) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next       = PH_LEAD;
                  fields_done_next = fields_done + FCNT_W'(1);
                end
              end else if (is_lf || is_cr) begin
                want_emit  = 1'b1;
                row_end    = 1'b1;
                phase_next = PH_DONE;
              end else if (eff_phase == PH_UNQ) begin
                want_append = 1'b1;
              end
            end
            PH_QUO: begin
              if (is_quote) begin
                phase_next = PH_QUO_Q;
              end else begin
                want_append = 1'b1;
              end
            end
            PH_QUO_Q: begin
              // A doubled quote: keep one literal quote.
              want_append = 1'b1;
              phase_next  = PH_QUO;
            end
            default: begin
            end
          endcase
        end
      end else begin
        // Line end: an open field is closed and ends the row.
        if ((phase == PH_LEAD) || (phase == PH_UNQ) || (phase == PH_QUO) ||
            (phase == PH_QUO_Q) || (phase == PH_AFTER)) begin
          want_emit = 1'b1;
          row_end   = 1'b1;
        end
        phase_next = PH_DONE;
        if (hold_eol) begin
          phase_next   = PH_START;
          line_restart = 1'b1;
        end
      end
    end
  end

  // A step waits while its bank is read out; an emit also on a full queue.
  always_comb begin
    stall = hold_valid &&
            ((((want_emit || want_append) && busy[cur_bank])) || (want_emit && cmd_full));
    go    = hold_valid && !stall;
  end

  // Bank ownership: set on handing over a field, cleared when it is read out.
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (go && want_emit) begin
      busy_next[cur_bank] = 1'b1;
    end
  end

  // Store write and field command.
  always_comb begin
    wr.en       = go && want_append && append_ok;
    wr.addr     = {cur_bank, stored_length};
    wr.data     = hold_byte;
    cmd_push    = go && want_emit;
    cmd.bank    = cur_bank;
    cmd.lo      = trim_lo;
    cmd.hi      = trim_hi;
    cmd.empty   = !seen;
    cmd.num     = NUM_W'(fields_done);
    cmd.row_end = row_end;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      line_step     <= 1'b0;
      phase         <= PH_START;
      stored_length <= '0;
      fields_done   <= '0;
      cur_bank      <= 1'b0;
      busy          <= '0;
      seen          <= 1'b0;
    end else begin
      busy <= busy_next;
      if (go) begin
        phase       <= phase_next;
        fields_done <= line_restart ? '0 : fields_done_next;
        if (want_emit || line_restart) begin
          stored_length <= '0;
          seen          <= 1'b0;
        end else if (want_append && append_ok) begin
          stored_length <= stored_length + LEN_W'(1);
          if (!ws) begin
            seen <= 1'b1;
          end
        end
        if (want_emit) begin
          cur_bank <= ~cur_bank;
        end
        // The line end step follows a NUL byte or the last byte of a line.
        if (!line_step && (hold_byte != CH_NUL) && !hold_eol) begin
          hold_valid <= 1'b0;
        end else if (!line_step) begin
          line_step <= 1'b1;
        end else begin
          hold_valid <= 1'b0;
          line_step  <= 1'b0;
        end
      end else if (push && !hold_valid) begin
        hold_valid <= 1'b1;
        line_step  <= 1'b0;
      end
    end
  end

  // Held byte and trim bounds of the field being stored.
  always_ff @(posedge clk) begin
    if (push && !hold_valid) begin
      hold_byte <= data_byte;
      hold_eol  <= end_of_line;
    end
    if (go && !want_emit && !line_restart && want_append && append_ok && !ws) begin
      if (!seen) begin
        trim_lo <= stored_length;
      end
      trim_hi <= stored_length + LEN_W'(1);
    end
  end

endmodule

// File: src/csvfs_cmd_queue.sv
// ----------------------------------------------------------------------------
// csvfs_cmd_queue
// Two-entry queue of field commands between the parser and the emitter.
// ----------------------------------------------------------------------------
module csvfs_cmd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  csvfs_pkg::field_cmd_t push_cmd,
  output logic                  full,
  input  logic                  pop,
  output csvfs_pkg::field_cmd_t head,
  output logic                  empty
);
  import csvfs_pkg::*;

  localparam int DEPTH = 2;

  field_cmd_t entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  // Status and head of the queue.
  always_comb begin
    full    = (count == 2'(DEPTH));
    empty   = (count == 2'd0);
    head    = entries[rd_ptr];
    do_push = push && !full;
    do_pop  = pop && !empty;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: src/csvfs_back.sv
// ----------------------------------------------------------------------------
// csvfs_back
// Emitter: holds the two-bank field store, takes field commands and reads
// the trimmed bytes out as result items, one per cycle while the results are popped.
// ----------------------------------------------------------------------------
module csvfs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  csvfs_pkg::store_wr_t            wr,
  input  csvfs_pkg::field_cmd_t           q_head,
  input  logic                            q_empty,
  output logic                            q_pop,
  output csvfs_pkg::bank_rel_t            rel,
  output logic                            empty,
  input  logic                            pop,
  output logic [csvfs_pkg::NUM_W-1:0]     field_number,
  output logic [7:0]                      field_byte,
  output logic                            field_empty,
  output logic                            last_of_field,
  output logic                            last_of_row
);
  import csvfs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [7:0]       mem [2**MEM_AW];
  logic             state;
  field_cmd_t       cur;
  logic [LEN_W-1:0] ptr;
  logic             out_valid;
  logic [NUM_W-1:0] o_num;
  logic             o_empty;
  logic             o_last_field;
  logic             o_last_row;
  logic [7:0]       rd_data;
  logic             slot_free;
  logic             issue;
  logic             last_byte;
  logic             item_last;

  // While running, issue an item whenever the output register is free or being taken.
  always_comb begin
    slot_free = !out_valid || pop;
    issue     = (state == ST_RUN) && slot_free;
    last_byte = ({1'b0, ptr} + (LEN_W + 1)'(1)) == {1'b0, cur.hi};
    item_last = cur.empty || last_byte;
    q_pop     = (state == ST_IDLE) && !q_empty;
    rel.valid = issue && item_last;
    rel.bank  = cur.bank;
  end

  // Result ports come straight from the output register.
  always_comb begin
    empty         = !out_valid;
    field_number  = o_num;
    field_byte    = o_empty ? 8'h00 : rd_data;
    field_empty   = o_empty;
    last_of_field = o_last_field;
    last_of_row   = o_last_row;
  end

  // Command sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue && item_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (issue) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Current command, read pointer and output item fields.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      ptr <= q_head.lo;
    end else if (issue) begin
      ptr <= ptr + LEN_W'(1);
    end
    if (issue) begin
      o_num        <= cur.num;
      o_empty      <= cur.empty;
      o_last_field <= item_last;
      o_last_row   <= item_last && cur.row_end;
    end
  end

  // Field store: one write port from the parser, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue && !cur.empty) begin
      rd_data <= mem[{cur.bank, ptr}];
    end
  end

endmodule

// File: src/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream of text lines into trimmed CSV fields.
// ----------------------------------------------------------------------------
// Bytes go in through a one-byte holding register, which shows full until
// the held byte is worked off; a NUL byte or the last byte of a line is
// held longer because the parser adds a line end step. The parser writes
// field bytes into one of two store banks of FIELD_BYTES bytes each and
// hands every finished field to the emitter through a two-entry command
// queue, so a new field can be parsed while the previous one is still being
// read out. A byte that must write to or close a field in a bank that is
// still being read out waits there. The emitter fetches each command in its
// idle state, then delivers one item per cycle from the store's registered
// read port as long as the results are popped. Trim bounds are tracked while
// the field is written, so no scan over the store is needed.
// ----------------------------------------------------------------------------
module csv_field_splitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_line,
  output logic                        empty,
  input  logic                        pop,
  output logic [csvfs_pkg::NUM_W-1:0] field_number,
  output logic [7:0]                  field_byte,
  output logic                        field_empty,
  output logic                        last_of_field,
  output logic                        last_of_row
);
  import csvfs_pkg::*;

  store_wr_t  wr;
  field_cmd_t cmd;
  field_cmd_t q_head;
  bank_rel_t  rel;
  logic       cmd_push;
  logic       cmd_full;
  logic       q_empty;
  logic       q_pop;

  // Parser and store writer.
  csvfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .end_of_line (end_of_line),
    .wr          (wr),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .cmd_full    (cmd_full),
    .rel         (rel)
  );

  // Field commands waiting for the emitter.
  csvfs_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (cmd_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Store and item emitter.
  csvfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .rel           (rel),
    .empty         (empty),
    .pop           (pop),
    .field_number  (field_number),
    .field_byte    (field_byte),
    .field_empty   (field_empty),
    .last_of_field (last_of_field),
    .last_of_row   (last_of_row)
  );

endmodule

// File: src/csvfs_checker.sv
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks of the CSV field splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_field_splitter_macros.svh"

module csvfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [csvfs_pkg::NUM_W-1:0] field_number,
  input logic [7:0]                  field_byte,
  input logic                        field_empty,
  input logic                        last_of_field,
  input logic                        last_of_row
);

  logic        held;
  logic        empty_item;
  logic [15:0] res;

  // A waiting result that is not taken, and everything it shows.
  assign held       = !empty && !pop;
  assign empty_item = !empty && field_empty;
  assign res        = {field_number, field_byte, field_empty, last_of_field, last_of_row};

  // Reset leaves both sides idle: no result waiting and room for an item.
  `CSVFS_ASSERT_ALWAYS(a_reset_idle, rst |=> (empty && !full), "reset did not clear the block")

  // An accepted item occupies the input until it has been worked off.
  `CSVFS_ASSERT(a_accept_full, (push && !full) |=> full, "accepted item left the input free")

  // A waiting result that is not taken stays as it is.
  `CSVFS_ASSERT(a_result_hold, held |=> !empty && $stable(res), "waiting result changed")

  // An empty field is a single item with a zero byte.
  `CSVFS_ASSERT(a_empty_item, empty_item |-> last_of_field && field_byte == 8'h00, "bad empty item")

  // The end of a row is always the end of a field.
  `CSVFS_ASSERT(a_row_end, (!empty && last_of_row) |-> last_of_field, "row ended inside a field")

endmodule

bind csv_field_splitter csvfs_checker u_checker (.*);
